// ===== hdl/gle_pkg.sv =====
// Shared constants for the GCD / LCM block.
// No dependencies; imported by gle_divider and gcd_lcm_euclid_top.
`timescale 1ns / 1ps

package gle_pkg;

  localparam int GLE_WIDTH = 32;
  localparam int OPND_W    = 32;
  localparam int PROD_W    = 64;

endpackage

// ===== hdl/gle_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on gle_pkg for the default operand width.
`timescale 1ns / 1ps

module gle_divider import gle_pkg::*; #(
  parameter int WIDTH = GLE_WIDTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic             busy;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  assign shifted = {rem, quo[WIDTH-1]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[WIDTH]) begin
        rem <= diff[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= shifted[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hdl/gcd_lcm_euclid_top.sv =====
// Top level of the GCD / LCM block: sequencer, operand registers, output register.
// Depends on gle_pkg and gle_divider.
`timescale 1ns / 1ps

// Computes gcd(a, b) by Euclid's remainder iteration and lcm = (a / gcd) * b at
// 2*WIDTH bits, on the low WIDTH bits of each operand. A single bit-serial divider
// does every remainder and the final quotient. Both operands zero go straight from
// idle to the finish state with both_zero set and zero results. in_stall is high
// from acceptance until the result is loaded into the output register, which holds
// it until out_stall is low.
module gcd_lcm_euclid_top import gle_pkg::*; #(
  parameter int WIDTH = GLE_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OPND_W-1:0] first_value,
  input  logic [OPND_W-1:0] second_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OPND_W-1:0] divisor_out,
  output logic [PROD_W-1:0] multiple_out,
  output logic              both_zero
);

  localparam int PW = 2 * WIDTH;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_GCD    = 5'b00010,
    ST_QUOT   = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state;

  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;
  logic [WIDTH-1:0] g;
  logic [WIDTH-1:0] quot;
  logic [PW-1:0]    prod;
  logic             flag;
  logic             div_wait;

  logic             div_start;
  logic             div_done;
  logic [WIDTH-1:0] div_dividend;
  logic [WIDTH-1:0] div_divisor;
  logic [WIDTH-1:0] div_quo;
  logic [WIDTH-1:0] div_rem;
  logic [PW-1:0]    mul_full;
  logic             in_take;
  logic             out_load;

  assign in_stall  = (state != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_load  = (state == ST_FINISH) && (!out_valid || !out_stall);

  assign div_start = !div_wait &&
                     (((state == ST_GCD) && (y != '0)) || (state == ST_QUOT));
  assign div_dividend = (state == ST_QUOT) ? a : x;
  assign div_divisor  = (state == ST_QUOT) ? g : y;
  assign mul_full     = {{WIDTH{1'b0}}, quot} * {{WIDTH{1'b0}}, b};

  gle_divider #(.WIDTH(WIDTH)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      div_wait <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (div_start) begin
        div_wait <= 1'b1;
      end else if (div_done) begin
        div_wait <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            if (first_value[WIDTH-1:0] == '0 && second_value[WIDTH-1:0] == '0) begin
              state <= ST_FINISH;
            end else begin
              state <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          if (!div_wait && y == '0) begin
            state <= ST_QUOT;
          end
        end
        ST_QUOT: begin
          if (div_wait && div_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          a    <= first_value[WIDTH-1:0];
          b    <= second_value[WIDTH-1:0];
          x    <= first_value[WIDTH-1:0];
          y    <= second_value[WIDTH-1:0];
          g    <= '0;
          prod <= '0;
          flag <= (first_value[WIDTH-1:0] == '0 && second_value[WIDTH-1:0] == '0);
        end
      end
      ST_GCD: begin
        if (!div_wait && y == '0) begin
          g <= x;
        end else if (div_wait && div_done) begin
          x <= y;
          y <= div_rem;
        end
      end
      ST_QUOT: begin
        if (div_wait && div_done) begin
          quot <= div_quo;
        end
      end
      ST_MUL: begin
        prod <= mul_full;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      divisor_out  <= OPND_W'(g);
      multiple_out <= PROD_W'(prod);
      both_zero    <= flag;
    end
  end

endmodule
